/* rtl/pds_pkg.sv */
// ----------------------------------------------------------------------------
// pds_pkg
// shared types and constants of the pentadiagonal solver
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int DEF_MAX_ORDER = 64;
  localparam int BAND_COUNT    = 5;
  localparam int Q_FRAC        = 16;
  localparam int DIV_STEPS     = 48;

  localparam logic [2:0] COL_M2  = 3'd0;
  localparam logic [2:0] COL_M1  = 3'd1;
  localparam logic [2:0] COL_DG  = 3'd2;
  localparam logic [2:0] COL_P1  = 3'd3;
  localparam logic [2:0] COL_P2  = 3'd4;
  localparam logic [2:0] COL_RHS = 3'd5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_ZDIAG = 2'd1;
  localparam logic [1:0] STAT_FAULT = 2'd2;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
    logic               flt;
  } div_rsp_t;

endpackage

/* rtl/pds_div.sv */
// ----------------------------------------------------------------------------
// pds_div
// iterative q16.16 divider, one quotient bit per cycle, saturating
// ----------------------------------------------------------------------------
module pds_div (
  input  logic             clk,
  input  logic             rst_n,
  input  pds_pkg::div_req_t req,
  output pds_pkg::div_rsp_t rsp
);
  import pds_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS + 1);
  localparam int DVD_W = 32 + Q_FRAC;

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [32:0]      rem_r;
  logic [DVD_W-1:0] dvd_r;
  logic [31:0]      dm_r;
  logic             neg_r;
  logic             done_r;
  logic [31:0]      quo_r;
  logic             flt_r;

  logic [32:0] nm, dmag, rem_sh, rem_sub;
  logic        take;
  logic [31:0] negq;

  always_comb begin
    nm      = req.num[31] ? (33'd0 - {req.num[31], req.num}) : {1'b0, req.num};
    dmag    = req.den[31] ? (33'd0 - {req.den[31], req.den}) : {1'b0, req.den};
    rem_sh  = {rem_r[31:0], dvd_r[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dm_r};
    take    = rem_sh >= {1'b0, dm_r};
    negq    = ~dvd_r[31:0] + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (req.den == 32'sd0) begin
          done_r <= 1'b1;
          flt_r  <= 1'b1;
          if (req.num[31]) begin
            quo_r <= 32'h8000_0000;
          end else if (req.num != 32'sd0) begin
            quo_r <= 32'h7FFF_FFFF;
          end else begin
            quo_r <= 32'd0;
          end
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
          rem_r  <= '0;
          dvd_r  <= {nm[31:0], {Q_FRAC{1'b0}}};
          dm_r   <= dmag[31:0];
          neg_r  <= req.num[31] ^ req.den[31];
        end
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(DIV_STEPS)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (neg_r) begin
            if (dvd_r > DVD_W'(32'h8000_0000)) begin
              quo_r <= 32'h8000_0000;
              flt_r <= 1'b1;
            end else begin
              quo_r <= negq;
              flt_r <= 1'b0;
            end
          end else begin
            if (dvd_r > DVD_W'(32'h7FFF_FFFF)) begin
              quo_r <= 32'h7FFF_FFFF;
              flt_r <= 1'b1;
            end else begin
              quo_r <= dvd_r[31:0];
              flt_r <= 1'b0;
            end
          end
        end else begin
          rem_r <= take ? rem_sub : rem_sh;
          dvd_r <= {dvd_r[DVD_W-2:0], take};
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = $signed(quo_r);
  assign rsp.flt  = flt_r;

endmodule

/* rtl/pentadiagonal_solver_core.sv */
// ----------------------------------------------------------------------------
// pentadiagonal_solver_core
// pentadiagonal solver, q16.16, gaussian elimination without pivoting
// ----------------------------------------------------------------------------
// each row request is written into the row memory column by column while
// in_stall is high; the last row starts the solve; elimination per row and
// back substitution per element are paced by the shared 48-step divider
// results leave from index n-1 down to 0; a zero diagonal on input gives one result
// synchronous reset clears control state only, the row memory is not cleared
// ----------------------------------------------------------------------------
module pentadiagonal_solver_core #(
  parameter int MAX_ORDER = pds_pkg::DEF_MAX_ORDER
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_band_minus2,
  input  logic signed [31:0] in_band_minus1,
  input  logic signed [31:0] in_diag,
  input  logic signed [31:0] in_band_plus1,
  input  logic signed [31:0] in_band_plus2,
  input  logic signed [31:0] in_rhs,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_solution,
  output logic [5:0]         out_index,
  output logic               out_last,
  output logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_order
);
  import pds_pkg::*;

  localparam int RW    = $clog2(MAX_ORDER);
  localparam int CW    = $clog2(MAX_ORDER + 1);
  localparam int AW    = RW + 3;
  localparam int DEPTH = MAX_ORDER * 8;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_RD, S_USE, S_MUL, S_RND, S_SUB, S_DIVW, S_OUT
  } st_t;

  typedef enum logic [2:0] {K_LD, K_DIVM, K_MSUB, K_INIT, K_ACC, K_SOL} kind_t;
  typedef enum logic [2:0] {R_PIV, R_U1, R_U2, R_RK, R_XP1, R_XP2} rsel_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] roff;
    logic [2:0] col;
    rsel_t      rs;
    logic       need1;
    logic       need2;
  } uop_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } sat_t;

  function automatic uop_t uop(input logic back, input logic [3:0] step);
    uop_t u;
    u = '{K_LD, 2'd0, COL_DG, R_PIV, 1'b0, 1'b0};
    if (back) begin
      unique case (step[1:0])
        2'd0: u = '{K_INIT, 2'd0, COL_RHS, R_PIV, 1'b0, 1'b0};
        2'd1: u = '{K_ACC,  2'd0, COL_P1,  R_XP1, 1'b1, 1'b0};
        2'd2: u = '{K_ACC,  2'd0, COL_P2,  R_XP2, 1'b0, 1'b1};
        default: u = '{K_SOL, 2'd0, COL_DG, R_PIV, 1'b0, 1'b0};
      endcase
    end else begin
      unique case (step)
        4'd0:  u = '{K_LD,   2'd0, COL_DG,  R_PIV, 1'b0, 1'b0};
        4'd1:  u = '{K_LD,   2'd0, COL_P1,  R_U1,  1'b0, 1'b0};
        4'd2:  u = '{K_LD,   2'd0, COL_P2,  R_U2,  1'b0, 1'b0};
        4'd3:  u = '{K_LD,   2'd0, COL_RHS, R_RK,  1'b0, 1'b0};
        4'd4:  u = '{K_DIVM, 2'd1, COL_M1,  R_PIV, 1'b0, 1'b0};
        4'd5:  u = '{K_MSUB, 2'd1, COL_DG,  R_U1,  1'b0, 1'b0};
        4'd6:  u = '{K_MSUB, 2'd1, COL_P1,  R_U2,  1'b0, 1'b1};
        4'd7:  u = '{K_MSUB, 2'd1, COL_RHS, R_RK,  1'b0, 1'b0};
        4'd8:  u = '{K_DIVM, 2'd2, COL_M2,  R_PIV, 1'b0, 1'b1};
        4'd9:  u = '{K_MSUB, 2'd2, COL_M1,  R_U1,  1'b0, 1'b1};
        4'd10: u = '{K_MSUB, 2'd2, COL_DG,  R_U2,  1'b0, 1'b1};
        default: u = '{K_MSUB, 2'd2, COL_RHS, R_RK, 1'b0, 1'b1};
      endcase
    end
    return u;
  endfunction

  function automatic sat_t sat50(input logic signed [49:0] v);
    sat_t s;
    s.clip = 1'b1;
    if (v > 50'sh0_0000_7FFF_FFFF) begin
      s.val = 32'sh7FFF_FFFF;
    end else if (v < -50'sh0_0000_8000_0000) begin
      s.val = -32'sh7FFF_FFFF - 32'sd1;
    end else begin
      s.val  = v[31:0];
      s.clip = 1'b0;
    end
    return s;
  endfunction

  st_t                state_r;
  logic [6:0]         order_r;
  logic [CW-1:0]      rows_r;
  logic               zdiag_r;
  logic [31:0]        ld_r [6];
  logic [RW-1:0]      lrow_r;
  logic [2:0]         lcol_r;
  logic               back_r;
  logic [CW-1:0]      k_r;
  logic [3:0]         step_r;
  logic               fault_r;
  logic               f2_r;
  logic signed [31:0] piv_r, u1_r, u2_r, rk_r, m_r, xp1_r, xp2_r, tgt_r;
  logic signed [63:0] prod_r;
  logic signed [47:0] q_r;
  logic signed [49:0] acc_r;
  logic               out_valid_r;
  logic signed [31:0] out_solution_r;
  logic [5:0]         out_index_r;
  logic               out_last_r;
  logic [1:0]         out_status_r;

  logic [31:0]        mem [DEPTH];
  logic [31:0]        rdata_r;

  logic [CW-1:0]      n_eff;
  logic [15:0]        ord_w;
  uop_t               op;
  logic [CW:0]        kw, nw, row_w;
  logic               has1, has2, op_en;
  logic [AW-1:0]      addr, wr_addr;
  logic               wr_en;
  logic [31:0]        wr_data;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] rnd;
  sat_t               diff_s, acc_s;
  logic signed [49:0] acc_sub;
  logic [CW-1:0]      adv_k;
  logic [3:0]         adv_step;
  logic               adv_back;
  logic [CW:0]        lnext;
  logic [15:0]        kx;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  pds_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    ord_w = 16'(order_r);
    if (ord_w < 16'd2) begin
      n_eff = CW'(2);
    end else if (ord_w > 16'(MAX_ORDER)) begin
      n_eff = CW'(MAX_ORDER);
    end else begin
      n_eff = CW'(order_r);
    end

    op    = uop(back_r, step_r);
    kw    = (CW + 1)'(k_r);
    nw    = (CW + 1)'(n_eff);
    has1  = (kw + (CW + 1)'(1)) < nw;
    has2  = (kw + (CW + 1)'(2)) < nw;
    op_en = (!op.need1 || has1) && (!op.need2 || has2);
    row_w = kw + (CW + 1)'(op.roff);
    addr  = {row_w[RW-1:0], op.col};
    lnext = (CW + 1)'(lrow_r) + (CW + 1)'(1);
    kx    = 16'(k_r);

    unique case (op.rs)
      R_PIV:   mul_b = piv_r;
      R_U1:    mul_b = u1_r;
      R_U2:    mul_b = u2_r;
      R_RK:    mul_b = rk_r;
      R_XP1:   mul_b = xp1_r;
      default: mul_b = xp2_r;
    endcase
    mul_a = (op.kind == K_MSUB) ? m_r : tgt_r;

    rnd     = prod_r + 64'sd32768;
    diff_s  = sat50({{18{tgt_r[31]}}, tgt_r} - {{2{q_r[47]}}, q_r});
    acc_sub = acc_r - {{2{q_r[47]}}, q_r};
    acc_s   = sat50(acc_r);

    wr_en   = (state_r == S_LOAD) || (state_r == S_SUB && op.kind == K_MSUB);
    wr_addr = (state_r == S_LOAD) ? {lrow_r, lcol_r} : addr;
    wr_data = (state_r == S_LOAD) ? ld_r[lcol_r] : diff_s.val;

    div_req.start = (state_r == S_USE) && (op.kind == K_DIVM || op.kind == K_SOL);
    div_req.num   = (op.kind == K_SOL) ? acc_s.val : $signed(rdata_r);
    div_req.den   = (op.kind == K_SOL) ? $signed(rdata_r) : piv_r;

    adv_back = back_r;
    adv_k    = k_r;
    adv_step = step_r + 4'd1;
    if (!back_r && step_r == 4'd11) begin
      adv_step = 4'd0;
      if (has2) begin
        adv_k = k_r + CW'(1);
      end else begin
        adv_back = 1'b1;
        adv_k    = n_eff - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      order_r     <= 7'd2;
      rows_r      <= '0;
      zdiag_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ld_r[0] <= in_band_minus2;
            ld_r[1] <= in_band_minus1;
            ld_r[2] <= in_diag;
            ld_r[3] <= in_band_plus1;
            ld_r[4] <= in_band_plus2;
            ld_r[5] <= in_rhs;
            lrow_r  <= (rows_r >= n_eff) ? '0 : rows_r[RW-1:0];
            lcol_r  <= COL_M2;
            if (in_diag == 32'sd0) begin
              zdiag_r <= 1'b1;
            end
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          lcol_r <= lcol_r + 3'd1;
          if (lcol_r == COL_RHS) begin
            if (lnext < nw) begin
              rows_r  <= lnext[CW-1:0];
              state_r <= S_IDLE;
            end else begin
              rows_r <= '0;
              if (zdiag_r) begin
                zdiag_r        <= 1'b0;
                out_valid_r    <= 1'b1;
                out_solution_r <= '0;
                out_index_r    <= '0;
                out_last_r     <= 1'b1;
                out_status_r   <= STAT_ZDIAG;
                state_r        <= S_OUT;
              end else begin
                back_r  <= 1'b0;
                k_r     <= '0;
                step_r  <= '0;
                fault_r <= 1'b0;
                state_r <= S_RD;
              end
            end
          end
        end
        S_RD: begin
          if (op_en) begin
            state_r <= S_USE;
          end else begin
            step_r <= adv_step;
            k_r    <= adv_k;
            back_r <= adv_back;
          end
        end
        S_USE: begin
          unique case (op.kind)
            K_LD: begin
              unique case (op.rs)
                R_PIV:   piv_r <= $signed(rdata_r);
                R_U1:    u1_r  <= $signed(rdata_r);
                R_U2:    u2_r  <= $signed(rdata_r);
                default: rk_r  <= $signed(rdata_r);
              endcase
              step_r  <= adv_step;
              k_r     <= adv_k;
              back_r  <= adv_back;
              state_r <= S_RD;
            end
            K_INIT: begin
              acc_r   <= {{18{rdata_r[31]}}, rdata_r};
              step_r  <= adv_step;
              state_r <= S_RD;
            end
            K_SOL: begin
              f2_r    <= acc_s.clip;
              state_r <= S_DIVW;
            end
            K_DIVM: begin
              state_r <= S_DIVW;
            end
            default: begin
              tgt_r   <= $signed(rdata_r);
              state_r <= S_MUL;
            end
          endcase
        end
        S_MUL: begin
          prod_r  <= mul_a * mul_b;
          state_r <= S_RND;
        end
        S_RND: begin
          q_r     <= rnd[63:16];
          state_r <= S_SUB;
        end
        S_SUB: begin
          if (op.kind == K_MSUB) begin
            fault_r <= fault_r | diff_s.clip;
          end else begin
            acc_r <= acc_sub;
          end
          step_r  <= adv_step;
          k_r     <= adv_k;
          back_r  <= adv_back;
          state_r <= S_RD;
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            if (!back_r) begin
              m_r     <= div_rsp.quo;
              fault_r <= fault_r | div_rsp.flt;
              step_r  <= adv_step;
              k_r     <= adv_k;
              back_r  <= adv_back;
              state_r <= S_RD;
            end else begin
              fault_r        <= fault_r | div_rsp.flt | f2_r;
              out_valid_r    <= 1'b1;
              out_solution_r <= div_rsp.quo;
              out_index_r    <= kx[5:0];
              out_last_r     <= (k_r == '0);
              out_status_r   <= (fault_r | div_rsp.flt | f2_r) ? STAT_FAULT : STAT_OK;
              state_r        <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              xp2_r   <= xp1_r;
              xp1_r   <= out_solution_r;
              k_r     <= k_r - CW'(1);
              step_r  <= '0;
              state_r <= S_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (cfg_we) begin
        order_r <= cfg_order;
        rows_r  <= '0;
        zdiag_r <= 1'b0;
      end
    end
  end

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_solution = out_solution_r;
  assign out_index    = out_index_r;
  assign out_last     = out_last_r;
  assign out_status   = out_status_r;

  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT)
    else $error("result shown outside output state");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIVW)
    else $error("divider finished while nobody waits");

  a_zdiag_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_ZDIAG |-> out_last && out_index == 6'd0)
    else $error("zero diagonal result not final");

  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_LOAD || state_r == S_SUB))
    else $error("row memory written outside load or update");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the pentadiagonal solver core
// ----------------------------------------------------------------------------
// row requests are fed from a directed table, then as random systems of mostly
// small order, one full 64-row system and some noise; a behavioral solver in
// the bench predicts every solution element, which is checked in order
// ----------------------------------------------------------------------------
module tb_top;
  import pds_pkg::*;

  localparam int ONE  = 32'h0001_0000;
  localparam int IMAX = 32'h7fff_ffff;
  localparam int IMIN = 32'h8000_0000;

  typedef struct {
    int m2, m1, dg, p1, p2, rhs;
    bit zd_typed;
  } row_t;

  typedef struct {
    logic signed [31:0] sol;
    logic [5:0]         idx;
    logic               last;
    logic [1:0]         st;
  } sol_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] in_band_minus2 = 0, in_band_minus1 = 0, in_diag = 0;
  logic signed [31:0] in_band_plus1 = 0, in_band_plus2 = 0, in_rhs = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] out_solution;
  logic [5:0] out_index;
  logic out_last;
  logic [1:0] out_status;
  logic cfg_we = 0;
  logic [6:0] cfg_order = 0;

  pentadiagonal_solver_core dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  // solver model state
  int band_m[64][5];
  int rhs_m[64];
  int rows_in;
  bit zd_seen;
  int order_reg = 2;
  bit clip;
  sol_t sol_q[$];
  sol_t fresh_q[$];

  int errors, systems, results, zd_runs, fault_runs, rows_sent, burst_left;

  function automatic int sat(longint v);
    if (v > longint'(IMAX)) begin
      clip = 1;
      return IMAX;
    end
    if (v < longint'(IMIN)) begin
      clip = 1;
      return IMIN;
    end
    return int'(v);
  endfunction

  function automatic longint qmul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b) + 32768;
    return p >>> 16;
  endfunction

  function automatic int qdiv(int n, int d);
    if (d == 0) begin
      clip = 1;
      return (n > 0) ? IMAX : (n < 0) ? IMIN : 0;
    end
    return sat((longint'(n) * 65536) / longint'(d));
  endfunction

  function automatic void solve_system(int n);
    int m;
    bit fault;
    longint acc;
    int num, x;
    sol_t s;
    clip = 0;
    for (int k = 0; k + 1 < n; k++) begin
      m = qdiv(band_m[k+1][COL_M1], band_m[k][COL_DG]);
      band_m[k+1][COL_DG] = sat(longint'(band_m[k+1][COL_DG]) - qmul(m, band_m[k][COL_P1]));
      if (k + 2 < n)
        band_m[k+1][COL_P1] = sat(longint'(band_m[k+1][COL_P1]) - qmul(m, band_m[k][COL_P2]));
      rhs_m[k+1] = sat(longint'(rhs_m[k+1]) - qmul(m, rhs_m[k]));
      if (k + 2 < n) begin
        m = qdiv(band_m[k+2][COL_M2], band_m[k][COL_DG]);
        band_m[k+2][COL_M1] = sat(longint'(band_m[k+2][COL_M1]) - qmul(m, band_m[k][COL_P1]));
        band_m[k+2][COL_DG] = sat(longint'(band_m[k+2][COL_DG]) - qmul(m, band_m[k][COL_P2]));
        rhs_m[k+2] = sat(longint'(rhs_m[k+2]) - qmul(m, rhs_m[k]));
      end
    end
    fault = clip;
    for (int k = n - 1; k >= 0; k--) begin
      acc = rhs_m[k];
      if (k + 1 < n) acc -= qmul(band_m[k][COL_P1], rhs_m[k+1]);
      if (k + 2 < n) acc -= qmul(band_m[k][COL_P2], rhs_m[k+2]);
      clip = 0;
      num = sat(acc);
      x = qdiv(num, band_m[k][COL_DG]);
      if (clip) fault = 1;
      rhs_m[k] = x;
      s.sol = x;
      s.idx = k[5:0];
      s.last = (k == 0);
      s.st = fault ? STAT_FAULT : STAT_OK;
      fresh_q.push_back(s);
    end
    if (fault) fault_runs++;
  endfunction

  function automatic void take_row(row_t r);
    int n, ri;
    sol_t s;
    n = (order_reg < 2) ? 2 : (order_reg > 64) ? 64 : order_reg;
    ri = (rows_in >= n) ? 0 : rows_in;
    band_m[ri] = '{r.m2, r.m1, r.dg, r.p1, r.p2};
    rhs_m[ri] = r.rhs;
    if (r.dg == 0) zd_seen = 1;
    rows_in = ri + 1;
    if (rows_in < n) return;
    rows_in = 0;
    systems++;
    if (zd_seen) begin
      zd_seen = 0;
      zd_runs++;
      s = '{sol: 0, idx: 0, last: 1, st: STAT_ZDIAG};
      fresh_q.push_back(s);
    end else
      solve_system(n);
  endfunction

  task automatic send_row(row_t r);
    sol_t s;
    in_band_minus2 <= r.m2;
    in_band_minus1 <= r.m1;
    in_diag        <= r.dg;
    in_band_plus1  <= r.p1;
    in_band_plus2  <= r.p2;
    in_rhs         <= r.rhs;
    in_valid       <= 1;
    do @(posedge clk); while (in_stall);
    rows_sent++;
    fresh_q.delete();
    take_row(r);
    if (r.zd_typed && fresh_q.size() != 0) begin
      s = '{sol: 0, idx: 0, last: 1, st: STAT_ZDIAG};
      sol_q.push_back(s);
    end else
      foreach (fresh_q[i]) sol_q.push_back(fresh_q[i]);
    if (burst_left > 0)
      burst_left--;
    else begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sol_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_order(int v);
    cfg_we <= 1;
    cfg_order <= v[6:0];
    @(posedge clk);
    cfg_we <= 0;
    order_reg = v & 8'h7f;
    rows_in = 0;
    zd_seen = 0;
  endtask

  function automatic int sgn_rand(int mag);
    return int'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  function automatic row_t good_row();
    row_t r;
    r.m2 = sgn_rand(ONE);
    r.m1 = sgn_rand(ONE);
    r.dg = 4 * ONE + int'($urandom_range(0, 4 * ONE));
    if ($urandom_range(0, 1)) r.dg = -r.dg;
    r.p1 = sgn_rand(ONE);
    r.p2 = sgn_rand(ONE);
    r.rhs = sgn_rand(16 * ONE);
    r.zd_typed = 0;
    return r;
  endfunction

  function automatic row_t noise_row();
    row_t r;
    r = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 0};
    return r;
  endfunction

  // kind 0 well formed, 1 one zero diagonal, 2 noise rows mixed in
  task automatic send_system(int n, int kind);
    int zrow;
    row_t r;
    zrow = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      r = good_row();
      if (kind == 2 && $urandom_range(0, 1)) r = noise_row();
      if (kind == 1 && i == zrow) r.dg = 0;
      send_row(r);
    end
  endtask

  row_t dir_rows[] = '{
    // outside bands set to extremes, they must be ignored
    '{IMAX, IMIN, 2*ONE, ONE, IMAX, 3*ONE, 0},
    '{IMIN, ONE, 2*ONE, IMAX, IMIN, 3*ONE, 0},
    // zero diagonal on input
    '{0, 0, 0, ONE, 0, ONE, 0},
    '{0, ONE, ONE, 0, 0, ONE, 1},
    // pivot becomes zero during elimination
    '{0, 0, ONE, ONE, 0, ONE, 0},
    '{0, ONE, ONE, 0, 0, 2*ONE, 0},
    // overflow paths
    '{0, 0, 1, IMAX, 0, IMAX, 0},
    '{0, IMIN, IMAX, 0, 0, IMIN, 0},
    '{0, 0, IMIN, IMIN, 0, IMAX, 0},
    '{0, IMAX, IMIN, 0, 0, IMIN, 0},
    '{0, 0, -ONE, -ONE, 0, -ONE, 0},
    '{0, -ONE, -3*ONE, 0, 0, -5*ONE, 0},
    // zero diagonal on both rows
    '{0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 1}
  };

  task automatic flag_mismatch(string what, sol_t got, sol_t want);
    $display("mismatch %s: got sol=%h idx=%0d last=%0b st=%0d, want sol=%h idx=%0d last=%0b st=%0d",
             what, got.sol, got.idx, got.last, got.st, want.sol, want.idx, want.last, want.st);
    errors++;
  endtask

  always @(posedge clk) begin
    sol_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{sol: out_solution, idx: out_index, last: out_last, st: out_status};
      results++;
      if (sol_q.size() == 0) begin
        want = '{sol: 'x, idx: 'x, last: 'x, st: 'x};
        flag_mismatch("unexpected result", got, want);
      end else begin
        want = sol_q.pop_front();
        if (got.sol !== want.sol) flag_mismatch("solution", got, want);
        if (got.idx !== want.idx) flag_mismatch("index", got, want);
        if (got.last !== want.last) flag_mismatch("last", got, want);
        if (got.st !== want.st) flag_mismatch("status", got, want);
      end
    end
  end

  // receiver stall pattern: quiet, light and heavy stretches
  int stall_left;
  int stall_mode;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 200);
    end else
      stall_left <= stall_left - 1;
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  initial begin
    int n, kind;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (dir_rows[i]) send_row(dir_rows[i]);
    drain();

    // partial load, then a new order restarts loading
    set_order(5);
    send_row(good_row());
    send_row(good_row());
    drain();
    set_order(0);
    send_system(2, 0);
    drain();
    set_order(1);
    send_system(2, 2);
    drain();
    set_order(127);
    send_system(64, 0);
    drain();

    while (rows_sent < 170) begin
      if ($urandom_range(0, 3) != 0) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(2, 6);
        set_order(n);
      end else
        n = (order_reg < 2) ? 2 : (order_reg > 64) ? 64 : order_reg;
      kind = $urandom_range(0, 9);
      kind = (kind < 8) ? 0 : (kind == 8) ? 1 : 2;
      send_system(n, kind);
      drain();
    end

    $display("ran %0d row requests into %0d systems, %0d results checked",
             rows_sent, systems, results);
    $display("zero diagonal runs %0d, runs with fault %0d", zd_runs, fault_runs);
    if (errors == 0 && sol_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
